// ===== rtl/core/arpu_pkg.sv =====
// arpu_pkg: relocation type codes, status codes, thumb keep masks and the
// internal kind enum for the relocation patch unit; no dependencies
package arpu_pkg;

   localparam logic [7:0] RELOC_NONE     = 8'd0;
   localparam logic [7:0] RELOC_ABS32    = 8'd2;
   localparam logic [7:0] RELOC_REL32    = 8'd3;
   localparam logic [7:0] RELOC_THM_CALL = 8'd10;
   localparam logic [7:0] RELOC_THM_JUMP = 8'd30;
   localparam logic [7:0] RELOC_TARGET1  = 8'd38;
   localparam logic [7:0] RELOC_PREL31   = 8'd42;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BOUNDS    = 2'd1;
   localparam logic [1:0] STATUS_BAD_TYPE  = 2'd2;
   localparam logic [1:0] STATUS_BAD_RANGE = 2'd3;

   localparam logic [15:0] THM_FIRST_KEEP  = 16'hF800;
   localparam logic [15:0] THM_SECOND_KEEP = 16'hD000;

   // what the second stage has to do with a request
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_ABS,
      KIND_REL,
      KIND_PREL31,
      KIND_THUMB,
      KIND_BAD
   } kind_type;

endpackage

// ===== rtl/core/arm_relocation_patch_unit_core.sv =====
// arm_relocation_patch_unit_core: patches one resolved arm elf relocation
// per request; depends on arpu_pkg
//
// One request is taken in every clock cycle: busy is always low, so start may
// stay high back to back. The request is captured in the stage one registers at
// the edge that takes it, and its result is registered in the result registers
// and is on the rsp_ ports for exactly one cycle with rsp_valid high. The
// receiver cannot stall the unit and must take every result as it comes.
// The first stage classifies the type, checks the bounds, decodes the thumb
// implicit addend and adds symbol and addend; the second stage finishes the
// address arithmetic, range checks and re-encodes the word. Nothing is kept
// from one request to the next.
module arm_relocation_patch_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_reloc_type,
   input  logic        req_with_explicit_addend,
   input  logic [31:0] req_original_word,
   input  logic [31:0] req_symbol_value,
   input  logic [31:0] req_place_address,
   input  logic signed [31:0] req_explicit_addend,
   input  logic [31:0] req_patch_offset,
   input  logic [31:0] req_section_size,
   output logic        rsp_valid,
   output logic [31:0] rsp_patched_word,
   output logic        rsp_write_enable,
   output logic [1:0]  rsp_status
);
   import arpu_pkg::*;

   // stage one registers
   logic        s1_valid_ff, s1_valid_in;
   kind_type    s1_kind_ff, s1_kind_in;
   logic [31:0] s1_sum_ff, s1_sum_in;      // symbol plus addend
   logic [31:0] s1_extra_ff, s1_extra_in;  // implicit addend, original word or zero
   logic [31:0] s1_place_ff;
   logic [31:0] s1_word_ff;
   logic        s1_extra_bounds_ff;

   // result registers
   logic        rsp_valid_ff;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic        rsp_we_ff, rsp_we_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // stage one logic
   logic        accept;
   logic        out_of_bounds;
   logic [32:0] end_offset;
   logic        is_thumb;
   logic [31:0] sym_operand;
   logic        thm_s, thm_j1, thm_j2, thm_i1, thm_i2;
   logic [31:0] thm_implicit;

   // stage two logic
   logic [31:0] sum_full;
   logic        thm_in_range;
   logic [15:0] thm_first, thm_second;

   // never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // offset is outside when fewer than 4 bytes remain after it
   assign end_offset    = {1'b0, req_patch_offset} + 33'd4;
   assign out_of_bounds = end_offset > {1'b0, req_section_size};

   always_comb begin
      if (out_of_bounds) begin
         s1_kind_in = KIND_BAD;
      end else begin
         unique case (req_reloc_type)
            RELOC_NONE:                     s1_kind_in = KIND_NONE;
            RELOC_ABS32, RELOC_TARGET1:     s1_kind_in = KIND_ABS;
            RELOC_REL32:                    s1_kind_in = KIND_REL;
            RELOC_PREL31:                   s1_kind_in = KIND_PREL31;
            RELOC_THM_CALL, RELOC_THM_JUMP: s1_kind_in = KIND_THUMB;
            default:                        s1_kind_in = KIND_BAD;
         endcase
      end
   end

   assign is_thumb = (req_reloc_type == RELOC_THM_CALL) ||
                     (req_reloc_type == RELOC_THM_JUMP);

   // thumb drops the interworking bit of the symbol
   assign sym_operand = is_thumb ? {req_symbol_value[31:1], 1'b0} : req_symbol_value;
   assign s1_sum_in   = sym_operand + req_explicit_addend;

   // decode s:i1:i2:imm10:imm11:0 from the two halfwords
   assign thm_s  = req_original_word[10];
   assign thm_j1 = req_original_word[29];
   assign thm_j2 = req_original_word[27];
   assign thm_i1 = ~(thm_j1 ^ thm_s);
   assign thm_i2 = ~(thm_j2 ^ thm_s);
   assign thm_implicit = {{7{thm_s}}, thm_s, thm_i1, thm_i2,
                          req_original_word[9:0], req_original_word[26:16], 1'b0};

   // the addend held in the word counts for rel entries only
   always_comb begin
      if (req_with_explicit_addend) begin
         s1_extra_in = 32'd0;
      end else if (is_thumb) begin
         s1_extra_in = thm_implicit;
      end else begin
         s1_extra_in = req_original_word;
      end
   end

   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= s1_kind_in;
         s1_sum_ff   <= s1_sum_in;
         s1_extra_ff <= s1_extra_in;
         s1_place_ff <= req_place_address;
         s1_word_ff  <= req_original_word;
      end
   end

   // stage two: finish the sum, place subtracted for pc relative kinds
   always_comb begin
      if (s1_kind_ff == KIND_ABS) begin
         sum_full = s1_sum_ff + s1_extra_ff;
      end else begin
         sum_full = s1_sum_ff + s1_extra_ff - s1_place_ff;
      end
   end

   // signed offset in [-2^24, 2^24-2] and even
   assign thm_in_range = ((sum_full[31:24] == 8'h00) || (sum_full[31:24] == 8'hFF)) &&
                         !sum_full[0];

   assign thm_first  = (s1_word_ff[15:0] & THM_FIRST_KEEP) |
                       {5'd0, sum_full[24], sum_full[21:12]};
   assign thm_second = (s1_word_ff[31:16] & THM_SECOND_KEEP) |
                       {2'd0, ~(sum_full[23] ^ sum_full[24]), 1'b0,
                        ~(sum_full[22] ^ sum_full[24]), sum_full[11:1]};

   always_comb begin
      rsp_word_in   = 32'd0;
      rsp_we_in     = 1'b0;
      rsp_status_in = STATUS_OK;
      unique case (s1_kind_ff)
         KIND_NONE: begin
         end
         KIND_ABS, KIND_REL: begin
            rsp_word_in = sum_full;
            rsp_we_in   = 1'b1;
         end
         KIND_PREL31: begin
            rsp_word_in = {s1_word_ff[31], sum_full[30:0]};
            rsp_we_in   = 1'b1;
         end
         KIND_THUMB: begin
            if (thm_in_range) begin
               rsp_word_in = {thm_second, thm_first};
               rsp_we_in   = 1'b1;
            end else begin
               rsp_status_in = STATUS_BAD_RANGE;
            end
         end
         KIND_BAD: begin
            // bounds failure was folded into this kind ahead of the type check
            rsp_status_in = (s1_extra_bounds_ff) ? STATUS_BOUNDS : STATUS_BAD_TYPE;
         end
         default: begin
            rsp_status_in = STATUS_BAD_TYPE;
         end
      endcase
   end

   // remember which kind of failure a bad kind stands for
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_extra_bounds_ff <= out_of_bounds;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_word_ff   <= rsp_word_in;
         rsp_we_ff     <= rsp_we_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_patched_word = rsp_word_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
